FILE: rtl/core/label_vote_confirmation_macros.svh
// assertion macros for the label vote confirmation block
`ifndef LABEL_VOTE_CONFIRMATION_MACROS_SVH
`define LABEL_VOTE_CONFIRMATION_MACROS_SVH
`ifndef NO_ASSERTIONS
`define LVC_ASSERT_IMP(name, a, c) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (a) |-> (c)) \
		else $error("assertion failed");
`define LVC_ASSERT_NEXT(name, a, c) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (a) |=> (c)) \
		else $error("assertion failed");
`else
`define LVC_ASSERT_IMP(name, a, c)
`define LVC_ASSERT_NEXT(name, a, c)
`endif
`endif

FILE: rtl/core/lvc_pkg.sv
// shared types, constants and helpers of the label vote confirmation block
`default_nettype none
package lvc_pkg;
	localparam int NUM_CLASSES = 16;
	localparam int PROB_BITS   = 16;
	localparam int ID_W        = 4;
	localparam int IDX_W       = $clog2(NUM_CLASSES);
	localparam int CNT_W       = 8;
	localparam int TOT_W       = CNT_W + IDX_W;
	localparam int RATIO_W     = 10;
	localparam int PROD_W      = RATIO_W + TOT_W;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 10;

	localparam logic [CNT_W-1:0] CNT_MAX = '1;

	localparam logic [CFG_IDX_W-1:0] REG_RATIO_DETECT   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAMES_DETECT  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_EMPTIES_DETECT = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_RATIO_TRACK    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_FRAMES_TRACK   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_EMPTIES_TRACK  = 3'd5;

	localparam logic [RATIO_W-1:0] RST_RATIO_DETECT   = 10'd154;
	localparam logic [CNT_W-1:0]   RST_FRAMES_DETECT  = 8'd3;
	localparam logic [CNT_W-1:0]   RST_EMPTIES_DETECT = 8'd8;
	localparam logic [RATIO_W-1:0] RST_RATIO_TRACK    = 10'd154;
	localparam logic [CNT_W-1:0]   RST_FRAMES_TRACK   = 8'd15;
	localparam logic [CNT_W-1:0]   RST_EMPTIES_TRACK  = 8'd5;

	typedef struct packed {
		logic [ID_W-1:0]      shape_id;
		logic [ID_W-1:0]      color_id;
		logic [PROB_BITS-1:0] shape_prob;
		logic                 phase;
	} in_word_t;

	typedef struct packed {
		logic                 shape_found;
		logic [ID_W-1:0]      shape_out;
		logic [PROB_BITS-1:0] shape_prob_out;
		logic                 color_found;
		logic [ID_W-1:0]      color_out;
	} out_word_t;

	typedef struct packed {
		logic                 clr;
		logic                 inc_shape;
		logic                 inc_color;
		logic [IDX_W-1:0]     shape;
		logic [IDX_W-1:0]     color;
		logic [PROB_BITS-1:0] prob;
	} upd_t;

	typedef struct packed {
		logic [IDX_W-1:0] shape_lead;
		logic [IDX_W-1:0] color_lead;
		logic             shape_ok;
		logic             color_ok;
	} lead_t;

	function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
		return (v == CNT_MAX) ? v : v + 1'b1;
	endfunction

	function automatic logic class_ok(input logic [ID_W-1:0] id);
		return (id != '0) && (32'(id) < NUM_CLASSES);
	endfunction
endpackage
`default_nettype wire

FILE: rtl/core/lvc_votes.sv
// vote counters per shape and color class and last probability per shape
`default_nettype none
module lvc_votes (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire lvc_pkg::upd_t                 upd,
	input  wire logic [lvc_pkg::IDX_W-1:0]     rd_idx,
	output logic [lvc_pkg::CNT_W-1:0]          shape_rd,
	output logic [lvc_pkg::CNT_W-1:0]          color_rd,
	input  wire logic [lvc_pkg::IDX_W-1:0]     prob_idx,
	output logic [lvc_pkg::PROB_BITS-1:0]      prob_rd
);
	logic [lvc_pkg::CNT_W-1:0]     shape_q [lvc_pkg::NUM_CLASSES];
	logic [lvc_pkg::CNT_W-1:0]     color_q [lvc_pkg::NUM_CLASSES];
	logic [lvc_pkg::PROB_BITS-1:0] prob_q  [lvc_pkg::NUM_CLASSES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < lvc_pkg::NUM_CLASSES; i++) begin
				shape_q[i] <= '0;
				color_q[i] <= '0;
			end
		end else begin
			for (int i = 0; i < lvc_pkg::NUM_CLASSES; i++) begin
				if (upd.clr) begin
					shape_q[i] <= (upd.inc_shape && upd.shape == lvc_pkg::IDX_W'(i)) ?
						lvc_pkg::CNT_W'(1) : '0;
					color_q[i] <= (upd.inc_color && upd.color == lvc_pkg::IDX_W'(i)) ?
						lvc_pkg::CNT_W'(1) : '0;
				end else begin
					if (upd.inc_shape && upd.shape == lvc_pkg::IDX_W'(i)) begin
						shape_q[i] <= lvc_pkg::sat_inc(shape_q[i]);
					end
					if (upd.inc_color && upd.color == lvc_pkg::IDX_W'(i)) begin
						color_q[i] <= lvc_pkg::sat_inc(color_q[i]);
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (upd.inc_shape) begin
			prob_q[upd.shape] <= upd.prob;
		end
	end

	assign shape_rd = shape_q[rd_idx];
	assign color_rd = color_q[rd_idx];
	assign prob_rd  = prob_q[prob_idx];
endmodule
`default_nettype wire

FILE: rtl/core/lvc_scan.sv
// iterative leader search and ratio test over both vote arrays
`default_nettype none
module lvc_scan (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	input  wire logic [lvc_pkg::RATIO_W-1:0]   ratio,
	output logic [lvc_pkg::IDX_W-1:0]          rd_idx,
	input  wire logic [lvc_pkg::CNT_W-1:0]     shape_vote,
	input  wire logic [lvc_pkg::CNT_W-1:0]     color_vote,
	output logic                               done,
	output lvc_pkg::lead_t                     lead
);
	localparam logic [1:0] SC_IDLE  = 2'd0;
	localparam logic [1:0] SC_WALK  = 2'd1;
	localparam logic [1:0] SC_CHK_S = 2'd2;
	localparam logic [1:0] SC_CHK_C = 2'd3;
	localparam logic [lvc_pkg::IDX_W-1:0] IDX_LAST = lvc_pkg::IDX_W'(lvc_pkg::NUM_CLASSES - 1);

	logic [1:0]                  st_q;
	logic [lvc_pkg::IDX_W-1:0]   idx_q;
	logic [lvc_pkg::CNT_W-1:0]   s_best_q, c_best_q;
	logic [lvc_pkg::IDX_W-1:0]   s_lead_q, c_lead_q;
	logic [lvc_pkg::TOT_W-1:0]   s_tot_q, c_tot_q;
	logic                        s_ok_q, c_ok_q, done_q;

	logic [lvc_pkg::CNT_W-1:0]   best_m;
	logic [lvc_pkg::TOT_W-1:0]   tot_m, rest;
	logic [lvc_pkg::PROD_W-1:0]  prod, lhs;
	logic                        pass;

	// one multiplier shared by the two lanes
	always_comb begin
		best_m = (st_q == SC_CHK_C) ? c_best_q : s_best_q;
		tot_m  = (st_q == SC_CHK_C) ? c_tot_q : s_tot_q;
		rest   = tot_m - lvc_pkg::TOT_W'(best_m);
		prod   = lvc_pkg::PROD_W'(ratio) * lvc_pkg::PROD_W'(rest);
		lhs    = lvc_pkg::PROD_W'({best_m, 8'h00});
		pass   = (best_m != '0) && (lhs > prod);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= SC_IDLE;
			idx_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (st_q)
				SC_IDLE: begin
					if (start) begin
						st_q  <= SC_WALK;
						idx_q <= '0;
					end
				end
				SC_WALK: begin
					idx_q <= idx_q + 1'b1;
					if (idx_q == IDX_LAST) begin
						st_q <= SC_CHK_S;
					end
				end
				SC_CHK_S: begin
					st_q <= SC_CHK_C;
				end
				SC_CHK_C: begin
					st_q   <= SC_IDLE;
					done_q <= 1'b1;
				end
				default: begin
					st_q <= SC_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == SC_IDLE && start) begin
			s_best_q <= '0;
			c_best_q <= '0;
			s_lead_q <= '0;
			c_lead_q <= '0;
			s_tot_q  <= '0;
			c_tot_q  <= '0;
		end else if (st_q == SC_WALK) begin
			if (shape_vote > s_best_q) begin
				s_best_q <= shape_vote;
				s_lead_q <= idx_q;
			end
			if (color_vote > c_best_q) begin
				c_best_q <= color_vote;
				c_lead_q <= idx_q;
			end
			s_tot_q <= s_tot_q + lvc_pkg::TOT_W'(shape_vote);
			c_tot_q <= c_tot_q + lvc_pkg::TOT_W'(color_vote);
		end
		if (st_q == SC_CHK_S) begin
			s_ok_q <= pass;
		end
		if (st_q == SC_CHK_C) begin
			c_ok_q <= pass;
		end
	end

	assign rd_idx          = idx_q;
	assign done            = done_q;
	assign lead.shape_lead = s_lead_q;
	assign lead.color_lead = c_lead_q;
	assign lead.shape_ok   = s_ok_q;
	assign lead.color_ok   = c_ok_q;
endmodule
`default_nettype wire

FILE: rtl/core/label_vote_confirmation.sv
// label vote confirmation: majority vote filter over per-frame class verdicts
//
// input channel: in_valid / in_ready with one frame verdict per word (shape,
// color, shape probability, phase). output channel: out_valid / out_ready with
// one confirmation word. configuration: cfg_we writes cfg_data into the
// register chosen by cfg_idx. the user must write it only while the block
// is idle; the block itself does not enforce this. a frame that triggers
// no evaluation is accepted and then passes the update state. a frame that
// triggers an evaluation goes through update, a walk over the vote counters
// (one class per cycle for both categories), two ratio checks on the shared
// multiplier, a handoff through the scan done register and the emit state,
// after which the input is freed again.
// in_ready is high only when the sequencer is idle.
// the result sits in an output register; a new frame is accepted while it
// waits. if the receiver stalls and a second result is ready, the emit cycle
// holds until the output register frees, and input stays blocked meanwhile.
// reset clears all votes, counters and the phase, loads the default register
// values and drops out_valid. no clearing pass is needed.
`default_nettype none
`include "label_vote_confirmation_macros.svh"
module label_vote_confirmation (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              in_valid,
	output logic                                   in_ready,
	input  wire lvc_pkg::in_word_t                 in_data,
	output logic                                   out_valid,
	input  wire logic                              out_ready,
	output lvc_pkg::out_word_t                     out_data,
	input  wire logic                              cfg_we,
	input  wire logic [lvc_pkg::CFG_IDX_W-1:0]     cfg_idx,
	input  wire logic [lvc_pkg::CFG_DATA_W-1:0]    cfg_data
);
	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_UPD  = 2'd1;
	localparam logic [1:0] ST_SCAN = 2'd2;
	localparam logic [1:0] ST_EMIT = 2'd3;

	logic [lvc_pkg::RATIO_W-1:0] ratio_detect_q, ratio_track_q;
	logic [lvc_pkg::CNT_W-1:0]   frames_detect_q, frames_track_q;
	logic [lvc_pkg::CNT_W-1:0]   empties_detect_q, empties_track_q;

	logic [1:0]                  st_q;
	lvc_pkg::in_word_t           item_q;
	logic                        prev_phase_q;
	logic [lvc_pkg::CNT_W-1:0]   er_q, df_q;
	logic                        out_valid_q;
	lvc_pkg::out_word_t          out_data_q;

	logic                        chg, s_ok, c_ok, empty_clr, eval, emit_fire, scan_start;
	logic [lvc_pkg::RATIO_W-1:0] ratio;
	logic [lvc_pkg::CNT_W-1:0]   frames, empties, er_base, er_inc, df_base, df_inc;
	lvc_pkg::upd_t               upd;
	lvc_pkg::lead_t              lead;
	lvc_pkg::out_word_t          result;
	logic [lvc_pkg::IDX_W-1:0]   rd_idx;
	logic [lvc_pkg::CNT_W-1:0]   shape_rd, color_rd;
	logic [lvc_pkg::PROB_BITS-1:0] prob_rd;
	logic                        scan_done;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ratio_detect_q   <= lvc_pkg::RST_RATIO_DETECT;
			frames_detect_q  <= lvc_pkg::RST_FRAMES_DETECT;
			empties_detect_q <= lvc_pkg::RST_EMPTIES_DETECT;
			ratio_track_q    <= lvc_pkg::RST_RATIO_TRACK;
			frames_track_q   <= lvc_pkg::RST_FRAMES_TRACK;
			empties_track_q  <= lvc_pkg::RST_EMPTIES_TRACK;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				lvc_pkg::REG_RATIO_DETECT:   ratio_detect_q   <= cfg_data;
				lvc_pkg::REG_FRAMES_DETECT:  frames_detect_q  <= cfg_data[lvc_pkg::CNT_W-1:0];
				lvc_pkg::REG_EMPTIES_DETECT: empties_detect_q <= cfg_data[lvc_pkg::CNT_W-1:0];
				lvc_pkg::REG_RATIO_TRACK:    ratio_track_q    <= cfg_data;
				lvc_pkg::REG_FRAMES_TRACK:   frames_track_q   <= cfg_data[lvc_pkg::CNT_W-1:0];
				lvc_pkg::REG_EMPTIES_TRACK:  empties_track_q  <= cfg_data[lvc_pkg::CNT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		chg       = item_q.phase != prev_phase_q;
		ratio     = item_q.phase ? ratio_track_q : ratio_detect_q;
		frames    = item_q.phase ? frames_track_q : frames_detect_q;
		empties   = item_q.phase ? empties_track_q : empties_detect_q;
		s_ok      = lvc_pkg::class_ok(item_q.shape_id);
		c_ok      = lvc_pkg::class_ok(item_q.color_id);
		er_base   = chg ? '0 : er_q;
		er_inc    = lvc_pkg::sat_inc(er_base);
		df_base   = chg ? '0 : df_q;
		df_inc    = lvc_pkg::sat_inc(df_base);
		empty_clr = !s_ok && (er_inc >= empties);
		eval      = s_ok && (df_inc > frames);
		emit_fire = (st_q == ST_EMIT) && (!out_valid_q || out_ready);
		scan_start = (st_q == ST_UPD) && eval;
	end

	always_comb begin
		upd           = '0;
		upd.shape     = lvc_pkg::IDX_W'(item_q.shape_id);
		upd.color     = lvc_pkg::IDX_W'(item_q.color_id);
		upd.prob      = item_q.shape_prob;
		if (st_q == ST_UPD) begin
			upd.clr       = chg || empty_clr;
			upd.inc_shape = s_ok;
			upd.inc_color = s_ok && c_ok;
		end else if (emit_fire) begin
			upd.clr       = 1'b1;
		end
	end

	always_comb begin
		result.shape_found    = lead.shape_ok && (lead.shape_lead != '0);
		result.shape_out      = result.shape_found ? lvc_pkg::ID_W'(lead.shape_lead) : '0;
		result.shape_prob_out = result.shape_found ? prob_rd : '0;
		result.color_found    = lead.color_ok && (lead.color_lead != '0);
		result.color_out      = result.color_found ? lvc_pkg::ID_W'(lead.color_lead) : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q         <= ST_IDLE;
			prev_phase_q <= 1'b0;
			er_q         <= '0;
			df_q         <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (st_q)
				ST_IDLE: begin
					if (in_valid) begin
						st_q <= ST_UPD;
					end
				end
				ST_UPD: begin
					prev_phase_q <= item_q.phase;
					if (s_ok) begin
						er_q <= '0;
						df_q <= df_inc;
					end else if (empty_clr) begin
						er_q <= '0;
						df_q <= '0;
					end else begin
						er_q <= er_inc;
						df_q <= df_base;
					end
					st_q <= eval ? ST_SCAN : ST_IDLE;
				end
				ST_SCAN: begin
					if (scan_done) begin
						st_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (emit_fire) begin
						df_q        <= '0;
						out_valid_q <= 1'b1;
						st_q        <= ST_IDLE;
					end
				end
				default: begin
					st_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_q <= in_data;
		end
		if (emit_fire) begin
			out_data_q <= result;
		end
	end

	lvc_votes u_votes (
		.clk      (clk),
		.arst_n   (arst_n),
		.upd      (upd),
		.rd_idx   (rd_idx),
		.shape_rd (shape_rd),
		.color_rd (color_rd),
		.prob_idx (lead.shape_lead),
		.prob_rd  (prob_rd)
	);

	lvc_scan u_scan (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (scan_start),
		.ratio      (ratio),
		.rd_idx     (rd_idx),
		.shape_vote (shape_rd),
		.color_vote (color_rd),
		.done       (scan_done),
		.lead       (lead)
	);

	assign in_ready  = (st_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	`LVC_ASSERT_NEXT(a_accept_updates, in_valid && in_ready, st_q == ST_UPD)
	`LVC_ASSERT_IMP(a_done_in_scan, scan_done, st_q == ST_SCAN)
	`LVC_ASSERT_IMP(a_no_shape_zero, out_valid && !out_data.shape_found,
		out_data.shape_out == '0 && out_data.shape_prob_out == '0)
	`LVC_ASSERT_IMP(a_found_nonzero, out_valid && out_data.color_found,
		out_data.color_out != '0)
endmodule
`default_nettype wire

FILE: test/tb.sv
// testbench of label_vote_confirmation: directed and random verdicts against a vote predictor
`timescale 1ns / 1ps
module tb;
	import lvc_pkg::*;

	localparam int STALL_LIMIT   = 4000;
	localparam int SETTLE_CYCLES = 40;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  in_valid  = 1'b0;
	logic                  in_ready;
	in_word_t              in_data   = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	out_word_t             out_data;
	logic                  cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_idx   = '0;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;

	int   send_idle_pct  = 0;
	int   recv_stall_pct = 0;
	int   error_count    = 0;
	int   quiet_cycles   = 0;
	logic cur_phase      = 1'b0;

	logic [CNT_W-1:0]     shape_tally [NUM_CLASSES];
	logic [CNT_W-1:0]     color_tally [NUM_CLASSES];
	logic [PROB_BITS-1:0] shape_prob_kept [NUM_CLASSES];
	logic [CNT_W-1:0]     empty_streak;
	logic [CNT_W-1:0]     frames_counted;
	logic                 phase_seen;
	logic [RATIO_W-1:0]   ratio_q [2];
	logic [CNT_W-1:0]     frames_q [2];
	logic [CNT_W-1:0]     empties_q [2];

	out_word_t confirmations_due [$];

	label_vote_confirmation DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.cfg_we(cfg_we),
		.cfg_idx(cfg_idx),
		.cfg_data(cfg_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] v);
		return (v == 8'hFF) ? v : v + 8'd1;
	endfunction

	function automatic void clear_tallies();
		for (int i = 0; i < NUM_CLASSES; i++) begin
			shape_tally[i] = '0;
			color_tally[i] = '0;
		end
		frames_counted = '0;
	endfunction

	function automatic void reset_predictor();
		clear_tallies();
		for (int i = 0; i < NUM_CLASSES; i++)
			shape_prob_kept[i] = '0;
		empty_streak = '0;
		phase_seen = 1'b0;
		ratio_q[0] = RST_RATIO_DETECT;
		frames_q[0] = RST_FRAMES_DETECT;
		empties_q[0] = RST_EMPTIES_DETECT;
		ratio_q[1] = RST_RATIO_TRACK;
		frames_q[1] = RST_FRAMES_TRACK;
		empties_q[1] = RST_EMPTIES_TRACK;
	endfunction

	function automatic void shadow_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] d);
		case (idx)
		REG_RATIO_DETECT: ratio_q[0] = d[RATIO_W-1:0];
		REG_FRAMES_DETECT: frames_q[0] = d[CNT_W-1:0];
		REG_EMPTIES_DETECT: empties_q[0] = d[CNT_W-1:0];
		REG_RATIO_TRACK: ratio_q[1] = d[RATIO_W-1:0];
		REG_FRAMES_TRACK: frames_q[1] = d[CNT_W-1:0];
		REG_EMPTIES_TRACK: empties_q[1] = d[CNT_W-1:0];
		default: ;
		endcase
	endfunction

	// lowest index wins ties, zero when the leader fails the ratio test
	function automatic logic [ID_W-1:0] confirmed_leader(input bit of_color,
			input logic [RATIO_W-1:0] ratio);
		longint unsigned v;
		longint unsigned best;
		longint unsigned total;
		logic [ID_W-1:0] lead;
		best = 0;
		total = 0;
		lead = '0;
		for (int i = 0; i < NUM_CLASSES; i++) begin
			v = of_color ? color_tally[i] : shape_tally[i];
			if (v > best) begin
				best = v;
				lead = ID_W'(i);
			end
			total += v;
		end
		if (best == 0)
			return '0;
		if (best * 256 > longint'(ratio) * (total - best))
			return lead;
		return '0;
	endfunction

	function automatic void vote_on_frame(input in_word_t w);
		logic [ID_W-1:0] s;
		logic [ID_W-1:0] c;
		out_word_t r;
		if (w.phase != phase_seen) begin
			clear_tallies();
			empty_streak = '0;
		end
		phase_seen = w.phase;
		if (w.shape_id == '0) begin
			empty_streak = bump(empty_streak);
			if (empty_streak >= empties_q[w.phase]) begin
				clear_tallies();
				empty_streak = '0;
			end
			return;
		end
		empty_streak = '0;
		frames_counted = bump(frames_counted);
		shape_tally[w.shape_id] = bump(shape_tally[w.shape_id]);
		shape_prob_kept[w.shape_id] = w.shape_prob;
		if (w.color_id != '0)
			color_tally[w.color_id] = bump(color_tally[w.color_id]);
		if (frames_counted <= frames_q[w.phase])
			return;
		s = confirmed_leader(1'b0, ratio_q[w.phase]);
		c = confirmed_leader(1'b1, ratio_q[w.phase]);
		r.shape_found = (s != '0);
		r.shape_out = s;
		r.shape_prob_out = (s != '0) ? shape_prob_kept[s] : '0;
		r.color_found = (c != '0);
		r.color_out = c;
		confirmations_due = {confirmations_due, r};
		clear_tallies();
	endfunction

	function automatic in_word_t make_frame(input int unsigned s, input int unsigned c,
			input int unsigned p, input bit ph);
		in_word_t w;
		w.shape_id = ID_W'(s);
		w.color_id = ID_W'(c);
		w.shape_prob = PROB_BITS'(p);
		w.phase = ph;
		return w;
	endfunction

	task automatic report_mismatch(input string what, input longint unsigned got,
			input longint unsigned want);
		error_count++;
		$display("%0t ns: %s mismatch, got %0h, want %0h", $time, what, got, want);
	endtask

	task automatic send_frame(input in_word_t w);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= w;
		do @(posedge clk); while (!in_ready);
		vote_on_frame(w);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (confirmations_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= CFG_DATA_W'(val);
		@(posedge clk);
		shadow_reg(idx, CFG_DATA_W'(val));
	endtask

	task automatic configure(input int unsigned rd, input int unsigned fd, input int unsigned ed,
			input int unsigned rt, input int unsigned ft, input int unsigned et);
		drain();
		write_reg(REG_RATIO_DETECT, rd);
		write_reg(REG_FRAMES_DETECT, fd);
		write_reg(REG_EMPTIES_DETECT, ed);
		write_reg(REG_RATIO_TRACK, rt);
		write_reg(REG_FRAMES_TRACK, ft);
		write_reg(REG_EMPTIES_TRACK, et);
		cfg_we <= 1'b0;
	endtask

	always @(posedge clk)
		out_ready <= ($urandom_range(99) >= recv_stall_pct);

	always @(posedge clk) begin : check_results
		out_word_t want;
		if (arst_n && out_valid && out_ready) begin
			if (confirmations_due.size() == 0) begin
				report_mismatch("unexpected result word", out_data, 0);
			end else begin
				want = confirmations_due.pop_front();
				if (out_data.shape_found !== want.shape_found)
					report_mismatch("shape_found", out_data.shape_found, want.shape_found);
				if (out_data.shape_out !== want.shape_out)
					report_mismatch("shape_out", out_data.shape_out, want.shape_out);
				if (out_data.shape_prob_out !== want.shape_prob_out)
					report_mismatch("shape_prob_out", out_data.shape_prob_out,
						want.shape_prob_out);
				if (out_data.color_found !== want.color_found)
					report_mismatch("color_found", out_data.color_found, want.color_found);
				if (out_data.color_out !== want.color_out)
					report_mismatch("color_out", out_data.color_out, want.color_out);
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("label_vote_confirmation verification failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// reset thresholds: leader with margin, lowest index on ties, empty run clearing
	task automatic test_reset_defaults();
		send_frame(make_frame(15, 15, 16'hFFFF, 0));
		send_frame(make_frame(15, 15, 16'h8000, 0));
		send_frame(make_frame(3, 1, 16'h1234, 0));
		send_frame(make_frame(15, 0, 16'hFFFF, 0));
		send_frame(make_frame(2, 2, 16'h0001, 0));
		send_frame(make_frame(1, 1, 16'h0002, 0));
		send_frame(make_frame(2, 1, 16'h0003, 0));
		send_frame(make_frame(1, 2, 16'h0004, 0));
		repeat (3) send_frame(make_frame(4, 4, 16'hAAAA, 0));
		repeat (8) send_frame(make_frame(0, $urandom_range(15), $urandom_range(16'hFFFF), 0));
		repeat (4) send_frame(make_frame(5, 6, 16'h5555, 0));
	endtask

	// ratio and threshold extremes, phase change, undefined color
	task automatic test_threshold_extremes();
		configure(1023, 1, 0, 0, 1, 255);
		send_frame(make_frame(1, 1, 16'h0000, 0));
		send_frame(make_frame(2, 2, 16'hFFFF, 0));
		send_frame(make_frame(3, 3, 16'h1111, 0));
		send_frame(make_frame(0, 15, 16'h2222, 0));
		send_frame(make_frame(3, 3, 16'h3333, 0));
		send_frame(make_frame(4, 4, 16'h4444, 0));
		send_frame(make_frame(6, 6, 16'h6666, 0));
		send_frame(make_frame(7, 7, 16'h7777, 1));
		send_frame(make_frame(7, 8, 16'h0000, 1));
		configure(154, 0, 3, 154, 0, 3);
		send_frame(make_frame(9, 0, 16'h0000, 0));
		send_frame(make_frame(15, 15, 16'hFFFF, 0));
		send_frame(make_frame(1, 0, 16'hFFFF, 1));
		send_frame(make_frame(8, 8, 16'h8001, 0));
	endtask

	// counters saturate when no evaluation can happen, empty run at its ceiling
	task automatic test_saturation();
		configure(154, 255, 255, 154, 15, 5);
		for (int k = 0; k < 260; k++) begin
			if (k % 10 == 0)
				send_frame(make_frame(8, 10, $urandom_range(16'hFFFF), 0));
			else
				send_frame(make_frame(7, 9, $urandom_range(16'hFFFF), 0));
		end
		repeat (254) send_frame(make_frame(0, 0, 0, 0));
		send_frame(make_frame(7, 9, 16'h1357, 0));
		configure(154, 0, 255, 154, 15, 5);
		send_frame(make_frame(7, 9, 16'hBEEF, 0));
		send_frame(make_frame(12, 3, 16'h0F0F, 0));
		repeat (255) send_frame(make_frame(0, 5, 16'hFFFF, 0));
		send_frame(make_frame(7, 9, 16'hCAFE, 0));
	endtask

	function automatic int unsigned pick_ratio();
		int unsigned r;
		r = $urandom_range(9);
		if (r == 0)
			return 0;
		if (r == 1)
			return 1023;
		return $urandom_range(600);
	endfunction

	function automatic int unsigned pick_empties();
		int unsigned r;
		r = $urandom_range(19);
		if (r < 2)
			return 0;
		if (r == 2)
			return 255;
		return $urandom_range(1, 10);
	endfunction

	// mostly runs with a dominant shape and color, some noise and empty runs
	task automatic random_frames(input int count);
		int sent;
		int kind;
		int len;
		int unsigned lead_s;
		int unsigned lead_c;
		in_word_t w;
		sent = 0;
		while (sent < count) begin
			kind = $urandom_range(99);
			if ($urandom_range(9) == 0)
				cur_phase = ~cur_phase;
			len = $urandom_range(1, 20);
			lead_s = $urandom_range(1, 15);
			lead_c = $urandom_range(15);
			for (int k = 0; k < len; k++) begin
				w.shape_prob = PROB_BITS'($urandom_range(16'hFFFF));
				w.phase = cur_phase;
				w.color_id = ID_W'($urandom_range(15));
				if (kind < 70) begin
					w.shape_id = ($urandom_range(9) < 7) ? ID_W'(lead_s) : ID_W'($urandom_range(15));
					if ($urandom_range(9) < 7)
						w.color_id = ID_W'(lead_c);
					if ($urandom_range(19) == 0)
						w.shape_id = '0;
				end else if (kind < 85) begin
					w.shape_id = ID_W'($urandom_range(15));
					w.phase = 1'($urandom_range(1));
				end else begin
					w.shape_id = ($urandom_range(3) == 0) ? ID_W'($urandom_range(15)) : '0;
				end
				send_frame(w);
			end
			sent += len;
		end
	endtask

	task automatic test_random_traffic(input int idle_pct, input int stall_pct, input int count);
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		for (int b = 0; b < 5; b++) begin
			configure(pick_ratio(), $urandom_range(16), pick_empties(),
				pick_ratio(), $urandom_range(16), pick_empties());
			random_frames(count / 5);
		end
	endtask

	initial begin
		reset_predictor();
		send_idle_pct = 30;
		recv_stall_pct = 80;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_threshold_extremes();
		test_saturation();
		test_random_traffic(30, 80, 320);
		test_random_traffic(80, 30, 320);
		test_random_traffic(0, 0, 330);
		drain();
		if (error_count == 0)
			$display("label_vote_confirmation verification clean");
		else
			$display("label_vote_confirmation verification failed");
		$finish;
	end
endmodule
